/* rtl/fwbq_pkg.sv */
// Shared types, fixed-point widths and coefficient tables for the frequency
// weighting biquad cascade. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fwbq_pkg;

	localparam int SAMPLE_W = 24;
	localparam int DLY_W    = 40;
	localparam int FRAC_W   = 16;
	localparam int COEF_W   = 25;
	localparam int RES_W    = 48;
	localparam int MEM_W    = 2 * DLY_W;

	// configuration register indexes
	localparam logic [3:0] REG_MODE = 4'd0;
	localparam logic [3:0] REG_RATE = 4'd1;

	// coefficient slots within one section
	localparam logic [2:0] OP_B0 = 3'd0;
	localparam logic [2:0] OP_B1 = 3'd1;
	localparam logic [2:0] OP_B2 = 3'd2;
	localparam logic [2:0] OP_A1 = 3'd3;
	localparam logic [2:0] OP_A2 = 3'd4;

	localparam logic signed [RES_W-1:0] DLY_MAX = 48'sd549755813887;
	localparam logic signed [RES_W-1:0] DLY_MIN = -48'sd549755813888;

	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic signed [DLY_W-1:0]    dly_t;
	typedef logic signed [RES_W-1:0]    prod_t;
	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic mode;   // 0: A weighting, 1: C weighting
		logic rate;   // 0: 16 kHz set, 1: 48 kHz set
	} cfg_t;

	typedef struct packed {
		logic    valid;
		sample_t sample;
	} res_t;

	// [rate][mode][section][b0,b1,b2,a1,a2], Q3.22
	localparam coef_t COEF_TAB [0:1][0:1][0:2][0:4] = '{
		'{ // 16 kHz
			'{ // A
				'{25'sd2219177, -25'sd4438354, 25'sd2219177, -25'sd8321025, 25'sd4126994},
				'{25'sd4194304, -25'sd8388608, 25'sd4194304, -25'sd7153427, 25'sd3003071},
				'{25'sd4194304,  25'sd8388608, 25'sd4194304,  25'sd3445889, 25'sd707755}
			},
			'{ // C
				'{25'sd2085356,  25'sd4170713, 25'sd2085356,  25'sd3445888, 25'sd707754},
				'{25'sd4194304, -25'sd8388608, 25'sd4194304, -25'sd8321024, 25'sd4126992},
				'{25'sd0, 25'sd0, 25'sd0, 25'sd0, 25'sd0}
			}
		},
		'{ // 48 kHz
			'{ // A
				'{25'sd982235,   25'sd1964470, 25'sd982235,  -25'sd941866,  25'sd52876},
				'{25'sd4194304, -25'sd8388608, 25'sd4194304, -25'sd7943469, 25'sd3754572},
				'{25'sd4194304, -25'sd8388608, 25'sd4194304, -25'sd8366019, 25'sd4171746}
			},
			'{ // C
				'{25'sd830014,   25'sd1660028, 25'sd830014,  -25'sd941866,  25'sd52876},
				'{25'sd4194304, -25'sd8388608, 25'sd4194304, -25'sd8366019, 25'sd4171746},
				'{25'sd0, 25'sd0, 25'sd0, 25'sd0, 25'sd0}
			}
		}
	};

	function automatic coef_t coef_of(input logic rate, input logic mode,
			input logic [1:0] sec, input logic [2:0] op);
		return COEF_TAB[rate][mode][sec][op];
	endfunction

	// clamp a wide sum to the 40-bit delay range
	function automatic dly_t sat_dly(input prod_t v);
		if (v > DLY_MAX)
			return dly_t'(DLY_MAX);
		else if (v < DLY_MIN)
			return dly_t'(DLY_MIN);
		else
			return v[DLY_W-1:0];
	endfunction

	// round Q24.16 to integer (half up), clamp to 24 bits
	function automatic sample_t sat_out(input dly_t y);
		logic signed [DLY_W:0]      t;
		logic signed [SAMPLE_W:0]   o;
		t = $signed({y[DLY_W-1], y}) + $signed((DLY_W+1)'(32768));
		o = t[DLY_W:FRAC_W];
		if (o > $signed(25'sd8388607))
			return sample_t'(24'h7FFFFF);
		else if (o < -$signed(25'sd8388608))
			return sample_t'(24'h800000);
		else
			return o[SAMPLE_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* rtl/fwbq_dmem.sv */
// Delay-state memory: one entry per section holding {d1, d2}.
// Synchronous (registered) read; per-entry valid bits give zero after reset.
`timescale 1ns / 1ps
`default_nettype none

module fwbq_dmem import fwbq_pkg::*; #(
	parameter int DEPTH = 3,
	parameter int AW    = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [MEM_W-1:0] rd_data,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [MEM_W-1:0] wr_data
);

	logic [MEM_W-1:0] mem [0:DEPTH-1];
	logic [DEPTH-1:0] vld_q;
	logic [MEM_W-1:0] rd_raw_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_raw_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en)
				vld_q[wr_addr] <= 1'b1;
			if (rd_en)
				rd_vld_q <= vld_q[rd_addr];
		end
	end

	// never-written entry reads as the reset value
	assign rd_data = rd_vld_q ? rd_raw_q : '0;

endmodule

`default_nettype wire

/* rtl/fwbq_mul.sv */
// Shared signal x coefficient multiplier: two 21x25 partial products, low half
// then high half, then sum and round to Q.16. Depends on fwbq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fwbq_mul import fwbq_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,   // operands held this cycle and the next
	input  wire dly_t  x,
	input  wire coef_t c,
	output prod_t      res      // registered result, held until the next product
);

	logic signed [20:0] a;
	logic signed [45:0] pp;
	logic signed [45:0] prod_q;
	logic signed [45:0] acc_q;
	logic signed [63:0] hi_w;
	logic signed [63:0] lo_w;
	logic signed [63:0] sum;
	logic               s1_q;
	logic               s2_q;
	prod_t              res_q;

	// low half unsigned on start cycle, high half signed on the next
	assign a  = start ? $signed({1'b0, x[19:0]}) : $signed({x[DLY_W-1], x[DLY_W-1:20]});
	assign pp = a * c;

	assign hi_w = 64'(prod_q);
	assign lo_w = 64'(acc_q);
	assign sum  = (hi_w <<< 20) + lo_w + 64'sd2097152;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q <= 1'b0;
			s2_q <= 1'b0;
		end else begin
			s1_q <= start;
			s2_q <= s1_q;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= pp;
		if (s1_q)
			acc_q <= prod_q;
		if (s2_q)
			res_q <= {{6{sum[63]}}, sum[63:22]};
	end

	assign res = res_q;

endmodule

`default_nettype wire

/* rtl/fwbq_ctrl.sv */
// Section sequencer: reads a section's delays, drives the shared multiplier,
// forms y, d1, d2 and writes back. Uses fwbq_pkg, fwbq_dmem, fwbq_mul.
`timescale 1ns / 1ps
`default_nettype none

module fwbq_ctrl import fwbq_pkg::*; #(
	parameter int NUM_SECTIONS = 3
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire sample_t sample_in,
	input  wire cfg_t    cfg,
	input  wire logic    out_free,
	output logic         busy,
	output res_t         res
);

	localparam int SEC_W = $clog2(NUM_SECTIONS);

	// steps within one section
	localparam logic [3:0] STP_RD  = 4'd0;   // read delays, load b0
	localparam logic [3:0] STP_MB0 = 4'd1;
	localparam logic [3:0] STP_LB1 = 4'd2;
	localparam logic [3:0] STP_MB1 = 4'd3;
	localparam logic [3:0] STP_Y   = 4'd4;   // y from b0*x + d1
	localparam logic [3:0] STP_MB2 = 4'd5;
	localparam logic [3:0] STP_P1  = 4'd6;
	localparam logic [3:0] STP_MA1 = 4'd7;
	localparam logic [3:0] STP_P2  = 4'd8;
	localparam logic [3:0] STP_MA2 = 4'd9;
	localparam logic [3:0] STP_D1  = 4'd10;
	localparam logic [3:0] STP_GAP = 4'd11;
	localparam logic [3:0] STP_WB  = 4'd12;  // write back, next section

	logic [3:0]       step_q;
	logic             busy_q;
	logic [SEC_W-1:0] sec_q;
	logic [SEC_W-1:0] last_sec;
	logic             last;
	logic             advance;

	dly_t  x_q;
	dly_t  y_q;
	dly_t  d1n_q;
	dly_t  d2n;
	prod_t m1_q;
	prod_t m2_q;
	coef_t c_q;
	logic  op_y_q;

	logic             mul_start;
	dly_t             mul_x;
	prod_t            mul_res;
	logic [MEM_W-1:0] rd_data;
	dly_t             d1_rd;
	dly_t             d2_rd;

	// C weighting uses two sections, A uses three, capped by the build
	assign last_sec = (cfg.mode || NUM_SECTIONS < 3) ? SEC_W'(1) : SEC_W'(2);
	assign last     = (sec_q == last_sec);
	assign advance  = !last || out_free;

	assign d1_rd = rd_data[MEM_W-1:DLY_W];
	assign d2_rd = rd_data[DLY_W-1:0];
	assign d2n   = sat_dly(m2_q - mul_res);

	assign mul_start = busy_q && (step_q == STP_MB0 || step_q == STP_MB1 ||
		step_q == STP_MB2 || step_q == STP_MA1 || step_q == STP_MA2);
	assign mul_x = op_y_q ? y_q : x_q;

	fwbq_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.x      (mul_x),
		.c      (c_q),
		.res    (mul_res)
	);

	fwbq_dmem #(
		.DEPTH (NUM_SECTIONS),
		.AW    (SEC_W)
	) u_dmem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (busy_q && step_q == STP_RD),
		.rd_addr (sec_q),
		.rd_data (rd_data),
		.wr_en   (busy_q && step_q == STP_WB),
		.wr_addr (sec_q),
		.wr_data ({d1n_q, d2n})
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= STP_RD;
			sec_q  <= '0;
		end else if (!busy_q) begin
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STP_RD;
				sec_q  <= '0;
			end
		end else if (step_q == STP_WB) begin
			if (advance) begin
				step_q <= STP_RD;
				sec_q  <= sec_q + SEC_W'(1);
				if (last)
					busy_q <= 1'b0;
			end
		end else begin
			step_q <= step_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q) begin
			if (start)
				x_q <= {sample_in, {FRAC_W{1'b0}}};
		end else begin
			unique case (step_q)
				STP_RD: begin
					c_q    <= coef_of(cfg.rate, cfg.mode, 2'(sec_q), OP_B0);
					op_y_q <= 1'b0;
				end
				STP_LB1: begin
					c_q <= coef_of(cfg.rate, cfg.mode, 2'(sec_q), OP_B1);
				end
				STP_Y: begin
					y_q <= sat_dly(mul_res + prod_t'(d1_rd));
					c_q <= coef_of(cfg.rate, cfg.mode, 2'(sec_q), OP_B2);
				end
				STP_P1: begin
					m1_q   <= mul_res;
					c_q    <= coef_of(cfg.rate, cfg.mode, 2'(sec_q), OP_A1);
					op_y_q <= 1'b1;
				end
				STP_P2: begin
					m2_q <= mul_res;
					c_q  <= coef_of(cfg.rate, cfg.mode, 2'(sec_q), OP_A2);
				end
				STP_D1: begin
					d1n_q <= sat_dly(m1_q - mul_res + prod_t'(d2_rd));
				end
				STP_WB: begin
					if (advance)
						x_q <= y_q;
				end
				default: ;
			endcase
		end
	end

	assign busy       = busy_q;
	assign res.valid  = busy_q && step_q == STP_WB && last;
	assign res.sample = sat_out(y_q);

endmodule

`default_nettype wire

/* rtl/frequency_weighting_biquad_cascade_top.sv */
// Top level of the A/C frequency weighting biquad cascade: stream ports,
// configuration registers, output register. Uses fwbq_pkg and fwbq_ctrl.
`timescale 1ns / 1ps
`default_nettype none

// Frequency weighting filter (A or C curve per IEC 61672-1) for signed 24-bit
// audio. Each sample runs through transposed direct-form II biquads: three
// sections for A weighting, two for C (fewer if NUM_SECTIONS is 2), with
// coefficients in Q3.22 from fixed 16 kHz or 48 kHz tables and 40-bit Q24.16
// delays kept in a small synchronous memory, one {d1, d2} entry per section,
// zero after reset. Every product is rounded half up to Q.16, every sum
// saturates to 40 bits, and the output is rounded and clamped to 24 bits.
// The sections run one after another through the one shared multiplier,
// which forms each product from two partial products, five products per
// section. A new sample is accepted only while the sequencer is idle, that
// is once the previous sample's last section has written back, and that
// write-back waits until the output register is free. The output register
// lets a new sample enter while the previous result waits. Configuration
// writes are always accepted (cfg_ready high); index 0 is weighting_mode,
// index 1 is rate_select, only bit 0 of the data counts, other indexes are
// ignored. Change them only when no sample is in flight; the delays are
// not cleared by a change.

module frequency_weighting_biquad_cascade_top import fwbq_pkg::*; #(
	parameter int NUM_SECTIONS = 3
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,   // [23:0] sample_in
	// output stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,   // [23:0] weighted_out
	// configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [3:0]  cfg_index,
	input  wire logic        cfg_data
);

	cfg_t        cfg_q;
	logic        busy;
	logic        start;
	logic        out_free;
	res_t        res;
	logic        m_vld_q;
	logic [23:0] m_data_q;

	// one sample at a time; accept only while the sequencer is idle
	assign s_axis_tready = !busy;
	assign start         = s_axis_tvalid && !busy;
	assign cfg_ready     = 1'b1;

	// output slot is free if empty or being drained this cycle
	assign out_free = !m_vld_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == REG_MODE)
				cfg_q.mode <= cfg_data;
			if (cfg_index == REG_RATE)
				cfg_q.rate <= cfg_data;
		end
	end

	fwbq_ctrl #(
		.NUM_SECTIONS (NUM_SECTIONS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.sample_in (s_axis_tdata),
		.cfg       (cfg_q),
		.out_free  (out_free),
		.busy      (busy),
		.res       (res)
	);

	// result register: the sequencer holds its last step until this takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_vld_q <= 1'b0;
		else if (res.valid && out_free)
			m_vld_q <= 1'b1;
		else if (m_axis_tready)
			m_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res.valid && out_free)
			m_data_q <= res.sample;
	end

	assign m_axis_tvalid = m_vld_q;
	assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire
